>>> rtl/rpnc_pkg.sv
// Shared types, codes and helpers for the RPN stack calculator.
`default_nettype none

package rpnc_pkg;

    // Width of one stack word and of the token opcode.
    localparam int DATA_W = 64;
    localparam int OP_W   = 4;

    // Defaults for the top-level parameters.
    localparam int STACK_DEPTH_DEF   = 128;
    localparam int FRACTION_BITS_DEF = 32;

    // Token opcodes; codes above OP_POPSHOW are unknown commands.
    typedef enum logic [OP_W-1:0] {
        OP_PUSH    = 4'd0,
        OP_ADD     = 4'd1,
        OP_SUB     = 4'd2,
        OP_MUL     = 4'd3,
        OP_DIV     = 4'd4,
        OP_MOD     = 4'd5,
        OP_PEEK    = 4'd6,
        OP_CLEAR   = 4'd7,
        OP_SWAP    = 4'd8,
        OP_DUP     = 4'd9,
        OP_POPSHOW = 4'd10
    } op_t;

    // Status codes reported with every result word.
    localparam logic [2:0] STAT_OK      = 3'd0;
    localparam logic [2:0] STAT_FULL    = 3'd1;
    localparam logic [2:0] STAT_EMPTY   = 3'd2;
    localparam logic [2:0] STAT_ZERO    = 3'd3;
    localparam logic [2:0] STAT_UNKNOWN = 3'd4;

    // Saturation limits of a signed 64-bit word.
    localparam logic [DATA_W-1:0] SIGN_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic [DATA_W-1:0] SIGN_MAX = {1'b0, {(DATA_W-1){1'b1}}};

    // Sequencer states of the top level.
    typedef enum logic [3:0] {
        S_IDLE,
        S_RD1,
        S_CAP1,
        S_RD2,
        S_CAP2,
        S_CALC,
        S_WAIT,
        S_PUSH,
        S_SWW1,
        S_SWW2,
        S_DONE
    } state_t;

    // Command from the sequencer to the arithmetic unit.
    typedef struct packed {
        logic start;
        op_t  op;
    } alu_cmd_t;

    // Magnitude of a two's complement word; the most negative value maps to itself.
    function automatic logic [DATA_W-1:0] mag(input logic [DATA_W-1:0] v);
        logic [DATA_W-1:0] r;
        r = v[DATA_W-1] ? (~v + 1'b1) : v;
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/rpn_stack_calculator.sv
// Top level of the reverse Polish stack calculator: token sequencer, stack memory and ALU.
//
//   Channel   Valid      Stall      Word fields
//   input     in_valid   in_stall   opcode, number
//   output    out_valid  out_stall  shown_value, shows, status, depth
//
// One token at a time. Mul and mod run the 64-step shift-add and restoring
// loops in the ALU, and div runs the restoring divider there.
// Reset empties the stack at once; the stack memory itself is not cleared.
// A finished word sits in the output register while the next token is taken.
`default_nettype none

module rpn_stack_calculator #(
    parameter int STACK_DEPTH   = rpnc_pkg::STACK_DEPTH_DEF,
    parameter int FRACTION_BITS = rpnc_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [rpnc_pkg::OP_W-1:0]       opcode,
    input  wire logic signed [rpnc_pkg::DATA_W-1:0] number,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic signed [rpnc_pkg::DATA_W-1:0]   shown_value,
    output logic                                 shows,
    output logic [2:0]                           status,
    output logic [7:0]                           depth
);

    localparam int W     = rpnc_pkg::DATA_W;
    localparam int AW    = $clog2(STACK_DEPTH);
    localparam int CNT_W = $clog2(STACK_DEPTH + 1);

    rpnc_pkg::state_t state_reg, state_next;
    rpnc_pkg::op_t    op_reg;
    logic [W-1:0]     num_reg;
    logic [W-1:0]     a_reg;
    logic [W-1:0]     b_reg;
    logic [W-1:0]     res_reg;
    logic [CNT_W-1:0] depth_reg;
    logic             empty_reg;
    logic             under_reg;
    logic [2:0]       stat_reg;
    logic [W-1:0]     shown_reg;
    logic             shows_reg;

    logic             out_valid_reg;
    logic [W-1:0]     out_value_reg;
    logic             out_shows_reg;
    logic [2:0]       out_status_reg;
    logic [7:0]       out_depth_reg;

    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [W-1:0]     mem_wdata;
    logic [AW-1:0]    mem_raddr;
    logic [W-1:0]     mem_rdata;

    rpnc_pkg::alu_cmd_t alu_cmd;
    logic               alu_done;
    logic [W-1:0]       alu_result;

    logic             accept;
    logic             out_free;
    logic             dep_zero;
    logic             dep_lt2;
    logic             dep_room;
    logic             is_pop_op;
    logic [CNT_W-1:0] depth_m1;
    logic [CNT_W-1:0] depth_m2;
    logic [W-1:0]     rd_val;
    logic             ib_zero;
    logic [31:0]      depth_wide;

    // Shared conditions.
    always_comb
    begin
        accept    = in_valid && !in_stall;
        out_free  = !out_valid_reg || !out_stall;
        dep_zero  = (depth_reg == '0);
        dep_lt2   = (depth_reg < CNT_W'(2));
        dep_room  = (depth_reg < CNT_W'(STACK_DEPTH));
        depth_m1  = depth_reg - 1'b1;
        depth_m2  = depth_reg - CNT_W'(2);
        rd_val    = empty_reg ? '0 : mem_rdata;
        ib_zero   = ((rpnc_pkg::mag(b_reg) >> FRACTION_BITS) == '0);
        is_pop_op = (op_reg == rpnc_pkg::OP_ADD) || (op_reg == rpnc_pkg::OP_SUB) ||
                    (op_reg == rpnc_pkg::OP_MUL) || (op_reg == rpnc_pkg::OP_DIV) ||
                    (op_reg == rpnc_pkg::OP_MOD) || (op_reg == rpnc_pkg::OP_POPSHOW);
    end

    // Next-state logic of the token sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rpnc_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = rpnc_pkg::S_RD1;
                end
            end
            rpnc_pkg::S_RD1:
            begin
                unique case (op_reg)
                    rpnc_pkg::OP_PUSH:  state_next = rpnc_pkg::S_PUSH;
                    rpnc_pkg::OP_CLEAR: state_next = rpnc_pkg::S_DONE;
                    rpnc_pkg::OP_SWAP:  state_next = dep_lt2 ? rpnc_pkg::S_DONE
                                                             : rpnc_pkg::S_CAP1;
                    rpnc_pkg::OP_ADD, rpnc_pkg::OP_SUB, rpnc_pkg::OP_MUL,
                    rpnc_pkg::OP_DIV, rpnc_pkg::OP_MOD, rpnc_pkg::OP_PEEK,
                    rpnc_pkg::OP_DUP, rpnc_pkg::OP_POPSHOW:
                        state_next = rpnc_pkg::S_CAP1;
                    default:            state_next = rpnc_pkg::S_DONE;
                endcase
            end
            rpnc_pkg::S_CAP1:
            begin
                unique case (op_reg)
                    rpnc_pkg::OP_DUP: state_next = empty_reg ? rpnc_pkg::S_DONE
                                                             : rpnc_pkg::S_PUSH;
                    rpnc_pkg::OP_DIV: state_next = (rd_val == '0) ? rpnc_pkg::S_DONE
                                                                  : rpnc_pkg::S_RD2;
                    rpnc_pkg::OP_ADD, rpnc_pkg::OP_SUB, rpnc_pkg::OP_MUL,
                    rpnc_pkg::OP_MOD, rpnc_pkg::OP_SWAP:
                        state_next = rpnc_pkg::S_RD2;
                    default:          state_next = rpnc_pkg::S_DONE;
                endcase
            end
            rpnc_pkg::S_RD2:
            begin
                state_next = rpnc_pkg::S_CAP2;
            end
            rpnc_pkg::S_CAP2:
            begin
                priority if (op_reg == rpnc_pkg::OP_SWAP)
                begin
                    state_next = rpnc_pkg::S_SWW1;
                end
                else if (op_reg == rpnc_pkg::OP_MOD && ib_zero)
                begin
                    state_next = rpnc_pkg::S_DONE;
                end
                else
                begin
                    state_next = rpnc_pkg::S_CALC;
                end
            end
            rpnc_pkg::S_CALC:
            begin
                state_next = rpnc_pkg::S_WAIT;
            end
            rpnc_pkg::S_WAIT:
            begin
                if (alu_done)
                begin
                    state_next = rpnc_pkg::S_PUSH;
                end
            end
            rpnc_pkg::S_PUSH:
            begin
                state_next = rpnc_pkg::S_DONE;
            end
            rpnc_pkg::S_SWW1:
            begin
                state_next = rpnc_pkg::S_SWW2;
            end
            rpnc_pkg::S_SWW2:
            begin
                state_next = rpnc_pkg::S_DONE;
            end
            rpnc_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    state_next = rpnc_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = rpnc_pkg::S_IDLE;
            end
        endcase
    end

    // Memory, ALU and handshake controls.
    always_comb
    begin
        in_stall      = (state_reg != rpnc_pkg::S_IDLE);
        mem_we        = 1'b0;
        mem_waddr     = depth_reg[AW-1:0];
        mem_wdata     = res_reg;
        mem_raddr     = depth_m1[AW-1:0];
        alu_cmd.start = (state_reg == rpnc_pkg::S_CALC);
        alu_cmd.op    = op_reg;
        unique case (state_reg)
            rpnc_pkg::S_RD2:
            begin
                if (op_reg == rpnc_pkg::OP_SWAP)
                begin
                    mem_raddr = depth_m2[AW-1:0];
                end
            end
            rpnc_pkg::S_PUSH:
            begin
                mem_we = dep_room;
            end
            rpnc_pkg::S_SWW1:
            begin
                mem_we    = 1'b1;
                mem_waddr = depth_m1[AW-1:0];
                mem_wdata = a_reg;
            end
            rpnc_pkg::S_SWW2:
            begin
                mem_we    = 1'b1;
                mem_waddr = depth_m2[AW-1:0];
                mem_wdata = b_reg;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Control state: sequencer, stack count and output word valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rpnc_pkg::S_IDLE;
            depth_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                rpnc_pkg::S_RD1:
                begin
                    if (op_reg == rpnc_pkg::OP_CLEAR)
                    begin
                        depth_reg <= '0;
                    end
                    else if (is_pop_op && !dep_zero)
                    begin
                        depth_reg <= depth_m1;
                    end
                end
                rpnc_pkg::S_RD2:
                begin
                    if (op_reg != rpnc_pkg::OP_SWAP && !dep_zero)
                    begin
                        depth_reg <= depth_m1;
                    end
                end
                rpnc_pkg::S_PUSH:
                begin
                    if (dep_room)
                    begin
                        depth_reg <= depth_reg + 1'b1;
                    end
                end
                default:
                begin
                    depth_reg <= depth_reg;
                end
            endcase
            if (state_reg == rpnc_pkg::S_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Token datapath: operands, flags and the output word.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            rpnc_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    op_reg    <= rpnc_pkg::op_t'(opcode);
                    num_reg   <= number;
                    under_reg <= 1'b0;
                    stat_reg  <= rpnc_pkg::STAT_OK;
                    shown_reg <= '0;
                    shows_reg <= 1'b0;
                end
            end
            rpnc_pkg::S_RD1:
            begin
                empty_reg <= dep_zero;
                res_reg   <= num_reg;
                if (op_reg == rpnc_pkg::OP_SWAP && dep_lt2)
                begin
                    stat_reg <= rpnc_pkg::STAT_EMPTY;
                end
                else if (!(is_pop_op || op_reg == rpnc_pkg::OP_PUSH ||
                           op_reg == rpnc_pkg::OP_CLEAR || op_reg == rpnc_pkg::OP_PEEK ||
                           op_reg == rpnc_pkg::OP_DUP || op_reg == rpnc_pkg::OP_SWAP))
                begin
                    stat_reg <= rpnc_pkg::STAT_UNKNOWN;
                end
            end
            rpnc_pkg::S_CAP1:
            begin
                b_reg   <= rd_val;
                res_reg <= rd_val;
                if (is_pop_op && empty_reg)
                begin
                    under_reg <= 1'b1;
                end
                unique case (op_reg)
                    rpnc_pkg::OP_PEEK:
                    begin
                        if (empty_reg)
                        begin
                            stat_reg <= rpnc_pkg::STAT_EMPTY;
                        end
                        else
                        begin
                            shown_reg <= rd_val;
                            shows_reg <= 1'b1;
                        end
                    end
                    rpnc_pkg::OP_POPSHOW:
                    begin
                        shown_reg <= rd_val;
                        shows_reg <= 1'b1;
                    end
                    rpnc_pkg::OP_DUP:
                    begin
                        if (empty_reg)
                        begin
                            stat_reg <= rpnc_pkg::STAT_EMPTY;
                        end
                    end
                    rpnc_pkg::OP_DIV:
                    begin
                        if (rd_val == '0)
                        begin
                            stat_reg <= rpnc_pkg::STAT_ZERO;
                        end
                    end
                    default:
                    begin
                        shows_reg <= shows_reg;
                    end
                endcase
            end
            rpnc_pkg::S_RD2:
            begin
                empty_reg <= dep_zero;
            end
            rpnc_pkg::S_CAP2:
            begin
                a_reg <= rd_val;
                if (op_reg != rpnc_pkg::OP_SWAP && empty_reg)
                begin
                    under_reg <= 1'b1;
                end
                if (op_reg == rpnc_pkg::OP_MOD && ib_zero)
                begin
                    stat_reg <= rpnc_pkg::STAT_ZERO;
                end
            end
            rpnc_pkg::S_WAIT:
            begin
                if (alu_done)
                begin
                    res_reg <= alu_result;
                end
            end
            rpnc_pkg::S_PUSH:
            begin
                if (!dep_room)
                begin
                    stat_reg <= rpnc_pkg::STAT_FULL;
                end
            end
            rpnc_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    out_value_reg  <= shown_reg;
                    out_shows_reg  <= shows_reg;
                    out_status_reg <= under_reg ? rpnc_pkg::STAT_EMPTY : stat_reg;
                    out_depth_reg  <= depth_wide[7:0];
                end
            end
            default:
            begin
                res_reg <= res_reg;
            end
        endcase
    end

    assign depth_wide  = 32'(depth_reg);
    assign out_valid   = out_valid_reg;
    assign shown_value = out_value_reg;
    assign shows       = out_shows_reg;
    assign status      = out_status_reg;
    assign depth       = out_depth_reg;

    // Stack storage.
    rpnc_ram #(
        .WIDTH (W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Arithmetic unit.
    rpnc_alu #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (alu_cmd),
        .a      (a_reg),
        .b      (b_reg),
        .done   (alu_done),
        .result (alu_result)
    );

endmodule

`default_nettype wire

>>> rtl/rpnc_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none

module rpnc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> rtl/rpnc_alu.sv
// Multi-cycle arithmetic unit: saturating add/sub, shift-add multiply, restoring divide.
`default_nettype none

module rpnc_alu #(
    parameter int FRACTION_BITS = rpnc_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire rpnc_pkg::alu_cmd_t          cmd,
    input  wire logic [rpnc_pkg::DATA_W-1:0] a,
    input  wire logic [rpnc_pkg::DATA_W-1:0] b,
    output logic                             done,
    output logic      [rpnc_pkg::DATA_W-1:0] result
);

    localparam int W      = rpnc_pkg::DATA_W;
    localparam int DIV_N  = W + FRACTION_BITS;
    localparam int CNT_W  = $clog2(DIV_N + 1);

    logic               busy_reg;
    logic               done_reg;
    logic [CNT_W-1:0]   cnt_reg;
    rpnc_pkg::op_t      op_reg;
    logic               neg_reg;
    logic [W-1:0]       ua_reg;
    logic [2*W-1:0]     p_reg;
    logic [W-1:0]       rem_reg;
    logic [W-1:0]       q_reg;
    logic               over_reg;

    logic [W:0]         mul_sum;
    logic [W:0]         rem_sh;
    logic               q_bit;
    logic [W:0]         rem_diff;
    logic [2*W-1:0]     prod_sh;
    logic [W-1:0]       mod_r;

    // Saturate a sign and a 128-bit magnitude split into an overflow flag and low word.
    function automatic logic [W-1:0] sat(input logic neg, input logic hi,
                                         input logic [W-1:0] lo);
        logic [W-1:0] r;
        if (neg)
        begin
            r = (hi || lo > rpnc_pkg::SIGN_MIN) ? rpnc_pkg::SIGN_MIN : (~lo + 1'b1);
        end
        else
        begin
            r = (hi || lo > rpnc_pkg::SIGN_MAX) ? rpnc_pkg::SIGN_MAX : lo;
        end
        return r;
    endfunction

    function automatic logic [W-1:0] add_sat(input logic [W-1:0] x, input logic [W-1:0] y);
        logic [W-1:0] s;
        s = x + y;
        if (x[W-1] == y[W-1] && s[W-1] != x[W-1])
        begin
            s = x[W-1] ? rpnc_pkg::SIGN_MIN : rpnc_pkg::SIGN_MAX;
        end
        return s;
    endfunction

    function automatic logic [W-1:0] sub_sat(input logic [W-1:0] x, input logic [W-1:0] y);
        logic [W-1:0] d;
        d = x - y;
        if (x[W-1] != y[W-1] && d[W-1] != x[W-1])
        begin
            d = x[W-1] ? rpnc_pkg::SIGN_MIN : rpnc_pkg::SIGN_MAX;
        end
        return d;
    endfunction

    // One iteration of the multiply and of the divide.
    always_comb
    begin
        mul_sum  = {1'b0, p_reg[2*W-1:W]} + (p_reg[0] ? {1'b0, ua_reg} : {(W+1){1'b0}});
        rem_sh   = {rem_reg, p_reg[2*W-1]};
        rem_diff = rem_sh - {1'b0, ua_reg};
        q_bit    = (rem_sh >= {1'b0, ua_reg});
    end

    // Final result selection with saturation.
    always_comb
    begin
        prod_sh = p_reg >> FRACTION_BITS;
        mod_r   = rem_reg << FRACTION_BITS;
        unique case (op_reg)
            rpnc_pkg::OP_MUL: result = sat(neg_reg, |prod_sh[2*W-1:W], prod_sh[W-1:0]);
            rpnc_pkg::OP_DIV: result = sat(neg_reg, over_reg, q_reg);
            rpnc_pkg::OP_MOD: result = neg_reg ? (~mod_r + 1'b1) : mod_r;
            default:          result = q_reg;
        endcase
    end

    assign done = done_reg;

    // Control registers of the iteration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.start)
            begin
                busy_reg <= 1'b1;
                unique case (cmd.op)
                    rpnc_pkg::OP_MUL: cnt_reg <= CNT_W'(W - 1);
                    rpnc_pkg::OP_DIV: cnt_reg <= CNT_W'(DIV_N - 1);
                    rpnc_pkg::OP_MOD: cnt_reg <= CNT_W'(W - 1);
                    default:          cnt_reg <= '0;
                endcase
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    // Operand load and datapath iteration.
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            op_reg   <= cmd.op;
            rem_reg  <= '0;
            over_reg <= 1'b0;
            q_reg    <= '0;
            unique case (cmd.op)
                rpnc_pkg::OP_ADD:
                begin
                    q_reg <= add_sat(a, b);
                end
                rpnc_pkg::OP_SUB:
                begin
                    q_reg <= sub_sat(a, b);
                end
                rpnc_pkg::OP_MUL:
                begin
                    neg_reg <= a[W-1] ^ b[W-1];
                    ua_reg  <= rpnc_pkg::mag(a);
                    p_reg   <= {{W{1'b0}}, rpnc_pkg::mag(b)};
                end
                rpnc_pkg::OP_DIV:
                begin
                    neg_reg <= a[W-1] ^ b[W-1];
                    ua_reg  <= rpnc_pkg::mag(b);
                    p_reg   <= {rpnc_pkg::mag(a), {W{1'b0}}};
                end
                rpnc_pkg::OP_MOD:
                begin
                    neg_reg <= a[W-1];
                    ua_reg  <= rpnc_pkg::mag(b) >> FRACTION_BITS;
                    p_reg   <= {rpnc_pkg::mag(a) >> FRACTION_BITS, {W{1'b0}}};
                end
                default:
                begin
                    neg_reg <= 1'b0;
                end
            endcase
        end
        else if (busy_reg)
        begin
            if (op_reg == rpnc_pkg::OP_MUL)
            begin
                p_reg <= {mul_sum, p_reg[W-1:1]};
            end
            else if (op_reg == rpnc_pkg::OP_DIV || op_reg == rpnc_pkg::OP_MOD)
            begin
                p_reg    <= p_reg << 1;
                rem_reg  <= q_bit ? rem_diff[W-1:0] : rem_sh[W-1:0];
                q_reg    <= {q_reg[W-2:0], q_bit};
                over_reg <= over_reg | q_reg[W-1];
            end
        end
    end

endmodule

`default_nettype wire

>>> test/rpn_stack_calculator_tb.sv
// Self-checking testbench for the RPN stack calculator: directed tokens, then random ones.
`default_nettype none

module rpn_stack_calculator_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH_MAX = 128;
    localparam int FRAC      = 32;
    localparam int RANDOM_TOKENS = 690;
    localparam longint CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic [63:0] shown_value;
        logic        shows;
        logic [2:0]  status;
        logic [7:0]  depth;
    } calc_word_t;

    // One directed token; the expected word is typed in only when check_fixed is set.
    typedef struct {
        logic [3:0]  opcode;
        logic [63:0] number;
        bit          check_fixed;
        calc_word_t  fixed;
    } token_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [3:0]  opcode;
    logic signed [63:0] number;
    logic        out_valid;
    logic        out_stall;
    logic signed [63:0] shown_value;
    logic        shows;
    logic [2:0]  status;
    logic [7:0]  depth;

    rpn_stack_calculator i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .opcode      (opcode),
        .number      (number),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .shown_value (shown_value),
        .shows       (shows),
        .status      (status),
        .depth       (depth)
    );

    // Predictor state: a private copy of the stack.
    logic [63:0] calc_stack [DEPTH_MAX];
    int          calc_depth;
    calc_word_t  expected_words [$];
    int          error_count;
    int          send_idle_pct;
    int          recv_idle_pct;
    bit          hold_off;
    bit          stimulus_done;
    longint      cycle_count;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #2 clk = ~clk;
        end
    end

    function automatic logic [63:0] magn(input logic [63:0] v);
        return v[63] ? (64'd0 - v) : v;
    endfunction

    function automatic logic [63:0] clamp_signed(input bit neg, input logic [127:0] m);
        if (neg)
            return (m > 128'h8000_0000_0000_0000) ? rpnc_pkg::SIGN_MIN : (64'd0 - m[63:0]);
        return (m > 128'h7FFF_FFFF_FFFF_FFFF) ? rpnc_pkg::SIGN_MAX : m[63:0];
    endfunction

    function automatic logic [63:0] pop_operand(inout bit under);
        if (calc_depth > 0)
        begin
            calc_depth--;
            return calc_stack[calc_depth];
        end
        under = 1'b1;
        return 64'd0;
    endfunction

    function automatic bit push_operand(input logic [63:0] v);
        if (calc_depth < DEPTH_MAX)
        begin
            calc_stack[calc_depth] = v;
            calc_depth++;
            return 1'b0;
        end
        return 1'b1;
    endfunction

    // Computes the word that one token produces and updates the stack copy.
    function automatic calc_word_t evaluate_token(input logic [3:0] op, input logic [63:0] num);
        calc_word_t w;
        bit under;
        bit neg;
        logic [63:0] a, b, t, ia, ib, r;
        logic [127:0] wide;
        logic signed [64:0] sum;
        under = 1'b0;
        w.shown_value = 64'd0;
        w.shows = 1'b0;
        w.status = rpnc_pkg::STAT_OK;
        case (op)
            rpnc_pkg::OP_PUSH:
                if (push_operand(num)) w.status = rpnc_pkg::STAT_FULL;
            rpnc_pkg::OP_ADD, rpnc_pkg::OP_SUB:
            begin
                b = pop_operand(under);
                a = pop_operand(under);
                if (op == rpnc_pkg::OP_ADD)
                    sum = $signed({a[63], a}) + $signed({b[63], b});
                else
                    sum = $signed({a[63], a}) - $signed({b[63], b});
                if (sum[64] != sum[63])
                    t = sum[64] ? rpnc_pkg::SIGN_MIN : rpnc_pkg::SIGN_MAX;
                else
                    t = sum[63:0];
                void'(push_operand(t));
            end
            rpnc_pkg::OP_MUL:
            begin
                b = pop_operand(under);
                a = pop_operand(under);
                neg = a[63] ^ b[63];
                wide = ({64'd0, magn(a)} * {64'd0, magn(b)}) >> FRAC;
                void'(push_operand(clamp_signed(neg, wide)));
            end
            rpnc_pkg::OP_DIV:
            begin
                b = pop_operand(under);
                if (b == 64'd0)
                    w.status = rpnc_pkg::STAT_ZERO;
                else
                begin
                    a = pop_operand(under);
                    neg = a[63] ^ b[63];
                    wide = ({64'd0, magn(a)} << FRAC) / {64'd0, magn(b)};
                    void'(push_operand(clamp_signed(neg, wide)));
                end
            end
            rpnc_pkg::OP_MOD:
            begin
                b = pop_operand(under);
                a = pop_operand(under);
                ib = magn(b) >> FRAC;
                ia = magn(a) >> FRAC;
                if (ib == 64'd0)
                    w.status = rpnc_pkg::STAT_ZERO;
                else
                begin
                    r = (ia % ib) << FRAC;
                    void'(push_operand(a[63] ? (64'd0 - r) : r));
                end
            end
            rpnc_pkg::OP_PEEK:
                if (calc_depth > 0)
                begin
                    w.shown_value = calc_stack[calc_depth-1];
                    w.shows = 1'b1;
                end
                else
                    w.status = rpnc_pkg::STAT_EMPTY;
            rpnc_pkg::OP_CLEAR:
                calc_depth = 0;
            rpnc_pkg::OP_SWAP:
                if (calc_depth >= 2)
                begin
                    t = calc_stack[calc_depth-1];
                    calc_stack[calc_depth-1] = calc_stack[calc_depth-2];
                    calc_stack[calc_depth-2] = t;
                end
                else
                    w.status = rpnc_pkg::STAT_EMPTY;
            rpnc_pkg::OP_DUP:
                if (calc_depth > 0)
                begin
                    if (push_operand(calc_stack[calc_depth-1])) w.status = rpnc_pkg::STAT_FULL;
                end
                else
                    w.status = rpnc_pkg::STAT_EMPTY;
            rpnc_pkg::OP_POPSHOW:
            begin
                w.shown_value = pop_operand(under);
                w.shows = 1'b1;
            end
            default:
                w.status = rpnc_pkg::STAT_UNKNOWN;
        endcase
        if (under) w.status = rpnc_pkg::STAT_EMPTY;
        w.depth = calc_depth[7:0];
        return w;
    endfunction

    // Offers one word and waits for it to be taken; the prediction is queued on acceptance.
    task automatic send_token(input logic [3:0] op, input logic [63:0] num,
                              input bit check_fixed, input calc_word_t fixed);
        calc_word_t w;
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            opcode <= 4'($urandom);
            number <= {$urandom, $urandom};
            @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode <= op;
        number <= num;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        w = evaluate_token(op, num);
        if (check_fixed && w != fixed)
        begin
            $display("%0t: directed token op %0d: table %h/%b/%0d/%0d, predictor %h/%b/%0d/%0d",
                     $realtime, op, fixed.shown_value, fixed.shows, fixed.status, fixed.depth,
                     w.shown_value, w.shows, w.status, w.depth);
            error_count++;
        end
        expected_words.push_back(check_fixed ? fixed : w);
    endtask

    function automatic calc_word_t word_of(input logic [63:0] v, input bit s,
                                           input logic [2:0] st, input int d);
        calc_word_t w;
        w.shown_value = v;
        w.shows = s;
        w.status = st;
        w.depth = d[7:0];
        return w;
    endfunction

    function automatic logic [63:0] random_value();
        case ($urandom_range(5))
            0: return rpnc_pkg::SIGN_MIN;
            1: return rpnc_pkg::SIGN_MAX;
            2: return {{32{$urandom_range(1) == 1}}, $urandom};
            3: return 64'(signed'($urandom_range(40) - 20)) << FRAC;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Random token: a mix of pushes, arithmetic and stack commands, with some noise.
    task automatic send_random_token();
        int pick;
        logic [3:0] op;
        pick = $urandom_range(99);
        if (pick < 35)
            op = rpnc_pkg::OP_PUSH;
        else if (pick < 70)
            op = 4'($urandom_range(rpnc_pkg::OP_MOD, rpnc_pkg::OP_ADD));
        else if (pick < 93)
            op = 4'($urandom_range(rpnc_pkg::OP_POPSHOW, rpnc_pkg::OP_PEEK));
        else
            op = 4'($urandom_range(15, 11));
        if (op == rpnc_pkg::OP_CLEAR && $urandom_range(3) != 0) op = rpnc_pkg::OP_PEEK;
        send_token(op, random_value(), 1'b0, word_of(0, 0, rpnc_pkg::STAT_OK, 0));
    endtask

    // Directed table walked after reset.
    token_row_t directed_rows [] = '{
        '{rpnc_pkg::OP_POPSHOW, 64'd0, 1'b1, '{64'd0, 1'b1, rpnc_pkg::STAT_EMPTY, 8'd0}},
        '{rpnc_pkg::OP_PEEK,    64'd0, 1'b1, '{64'd0, 1'b0, rpnc_pkg::STAT_EMPTY, 8'd0}},
        '{rpnc_pkg::OP_SWAP,    64'd0, 1'b1, '{64'd0, 1'b0, rpnc_pkg::STAT_EMPTY, 8'd0}},
        '{rpnc_pkg::OP_DUP,     64'd0, 1'b1, '{64'd0, 1'b0, rpnc_pkg::STAT_EMPTY, 8'd0}},
        '{rpnc_pkg::OP_ADD,     64'd0, 1'b1, '{64'd0, 1'b0, rpnc_pkg::STAT_EMPTY, 8'd1}},
        '{rpnc_pkg::OP_DIV,     64'd0, 1'b1, '{64'd0, 1'b0, rpnc_pkg::STAT_ZERO,  8'd0}},
        '{rpnc_pkg::OP_PUSH,    rpnc_pkg::SIGN_MAX, 1'b1,
          '{64'd0, 1'b0, rpnc_pkg::STAT_OK, 8'd1}},
        '{rpnc_pkg::OP_PEEK,    64'd0, 1'b1,
          '{rpnc_pkg::SIGN_MAX, 1'b1, rpnc_pkg::STAT_OK, 8'd1}},
        '{rpnc_pkg::OP_PUSH,    rpnc_pkg::SIGN_MAX, 1'b0,
          '{64'd0, 1'b0, rpnc_pkg::STAT_OK, 8'd0}},
        '{rpnc_pkg::OP_ADD,     64'd0, 1'b1, '{64'd0, 1'b0, rpnc_pkg::STAT_OK, 8'd1}},
        '{rpnc_pkg::OP_POPSHOW, 64'd0, 1'b1,
          '{rpnc_pkg::SIGN_MAX, 1'b1, rpnc_pkg::STAT_OK, 8'd0}},
        '{rpnc_pkg::OP_PUSH,    rpnc_pkg::SIGN_MIN, 1'b0,
          '{64'd0, 1'b0, rpnc_pkg::STAT_OK, 8'd0}},
        '{rpnc_pkg::OP_PUSH,    64'd1 << 32, 1'b0, '{64'd0, 1'b0, rpnc_pkg::STAT_OK, 8'd0}},
        '{rpnc_pkg::OP_SUB,     64'd0, 1'b0, '{64'd0, 1'b0, rpnc_pkg::STAT_OK, 8'd0}},
        '{rpnc_pkg::OP_PUSH,    -(64'd3 << 31), 1'b0,
          '{64'd0, 1'b0, rpnc_pkg::STAT_OK, 8'd0}},
        '{rpnc_pkg::OP_MUL,     64'd0, 1'b0, '{64'd0, 1'b0, rpnc_pkg::STAT_OK, 8'd0}},
        '{rpnc_pkg::OP_PUSH,    64'd7 << 32, 1'b0, '{64'd0, 1'b0, rpnc_pkg::STAT_OK, 8'd0}},
        '{rpnc_pkg::OP_SWAP,    64'd0, 1'b0, '{64'd0, 1'b0, rpnc_pkg::STAT_OK, 8'd0}},
        '{rpnc_pkg::OP_DIV,     64'd0, 1'b0, '{64'd0, 1'b0, rpnc_pkg::STAT_OK, 8'd0}},
        '{rpnc_pkg::OP_PUSH,    -(64'd17 << 32), 1'b0,
          '{64'd0, 1'b0, rpnc_pkg::STAT_OK, 8'd0}},
        '{rpnc_pkg::OP_PUSH,    64'd5 << 32, 1'b0, '{64'd0, 1'b0, rpnc_pkg::STAT_OK, 8'd0}},
        '{rpnc_pkg::OP_MOD,     64'd0, 1'b0, '{64'd0, 1'b0, rpnc_pkg::STAT_OK, 8'd0}},
        '{rpnc_pkg::OP_PUSH,    64'h0000_0000_8000_0000, 1'b0,
          '{64'd0, 1'b0, rpnc_pkg::STAT_OK, 8'd0}},
        '{rpnc_pkg::OP_MOD,     64'd0, 1'b0, '{64'd0, 1'b0, rpnc_pkg::STAT_OK, 8'd0}},
        '{4'd15,                64'd0, 1'b0, '{64'd0, 1'b0, rpnc_pkg::STAT_UNKNOWN, 8'd0}}
    };

    // Sender: reset, directed table, fill to full, then random tokens over three idle phases.
    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        opcode = '0;
        number = '0;
        calc_depth = 0;
        error_count = 0;
        send_idle_pct = 0;
        stimulus_done = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed_rows[i])
            send_token(directed_rows[i].opcode, directed_rows[i].number,
                       directed_rows[i].check_fixed, directed_rows[i].fixed);
        // Fill the stack, overflow it with push and dup, then send random tokens.
        send_token(rpnc_pkg::OP_CLEAR, 64'd0, 1'b1, word_of(0, 0, rpnc_pkg::STAT_OK, 0));
        for (int k = 0; k < DEPTH_MAX; k++)
            send_token(rpnc_pkg::OP_PUSH, random_value(), 1'b0,
                       word_of(0, 0, rpnc_pkg::STAT_OK, 0));
        send_token(rpnc_pkg::OP_PUSH, 64'd1, 1'b1,
                   word_of(0, 0, rpnc_pkg::STAT_FULL, DEPTH_MAX));
        send_token(rpnc_pkg::OP_DUP, 64'd0, 1'b1,
                   word_of(0, 0, rpnc_pkg::STAT_FULL, DEPTH_MAX));
        for (int k = 0; k < 60; k++)
            send_random_token();
        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 33 : (ph == 1) ? 55 : 0;
            for (int k = 0; k < RANDOM_TOKENS / 3; k++)
                send_random_token();
        end
        in_valid <= 1'b0;
        stimulus_done = 1'b1;
    end

    // Receiver: random stalls per phase, with one long hold-off early in the run.
    initial
    begin
        out_stall = 1'b0;
        hold_off = 1'b0;
        recv_idle_pct = 55;
        @(posedge rst_n);
        repeat (200) @(posedge clk);
        hold_off = 1'b1;
        repeat (3000) @(posedge clk);
        hold_off = 1'b0;
        wait (send_idle_pct == 55);
        recv_idle_pct = 33;
        wait (stimulus_done || send_idle_pct == 0);
        recv_idle_pct = 0;
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);
    end

    // Checker: compare each taken word with the oldest prediction.
    always @(posedge clk)
    begin
        calc_word_t w;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_words.size() == 0)
            begin
                $display("%0t: unexpected word %h/%b/%0d/%0d", $realtime,
                         shown_value, shows, status, depth);
                error_count++;
            end
            else
            begin
                w = expected_words.pop_front();
                if (w.shown_value !== shown_value || w.shows !== shows ||
                    w.status !== status || w.depth !== depth)
                begin
                    $display("%0t: expected %h/%b/%0d/%0d, got %h/%b/%0d/%0d", $realtime,
                             w.shown_value, w.shows, w.status, w.depth,
                             shown_value, shows, status, depth);
                    error_count++;
                end
            end
        end
    end

    // End of run and watchdog.
    initial
    begin
        cycle_count = 0;
        fork
            begin
                wait (stimulus_done);
                while (expected_words.size() != 0) @(posedge clk);
                repeat (200) @(posedge clk);
            end
            begin
                while (cycle_count < CYCLE_LIMIT)
                begin
                    @(posedge clk);
                    cycle_count++;
                end
                error_count++;
                $display("%0t: timeout with %0d words outstanding", $realtime,
                         expected_words.size());
            end
        join_any
        if (error_count == 0)
            $display("rpn_stack_calculator_tb passed");
        else
            $display("rpn_stack_calculator_tb failed");
        $finish;
    end

endmodule

`default_nettype wire
